[sv/scc_pkg.sv]
// Shared types, register indexes and constants for the streetlight schedule
// controller. Used by every module of the block; depends on nothing.
package scc_pkg;

  localparam int unsigned HourW     = 5;
  localparam int unsigned MinuteW   = 6;
  localparam int unsigned DayW      = 5;
  localparam int unsigned MonthW    = 4;
  localparam int unsigned YearW     = 12;
  localparam int unsigned SecondsW  = 32;
  localparam int unsigned LuxW      = 16;
  localparam int unsigned MarkW     = 11;
  localparam int unsigned DutyW     = 7;
  localparam int unsigned PeriodW   = 2;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned HoldW     = 16;

  localparam int unsigned MinutesPerHour = 60;
  localparam int unsigned HoursPerDay    = 24;
  localparam int unsigned MinutesPerDay  = HoursPerDay * MinutesPerHour;
  localparam int unsigned LastMonth      = 11;

  localparam logic [DutyW-1:0] DutyFull = 7'd100;

  localparam int unsigned DarkHoldDefault   = 60;
  localparam int unsigned ZoneOffsetDefault = 7;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_MARK_ONE   = 3'd0,
    CFG_MARK_TWO   = 3'd1,
    CFG_MARK_THREE = 3'd2,
    CFG_MARK_FOUR  = 3'd3,
    CFG_DUTY_ONE   = 3'd4,
    CFG_DUTY_TWO   = 3'd5,
    CFG_DUTY_THREE = 3'd6,
    CFG_DARK_LUX   = 3'd7
  } cfg_idx_e;

  typedef enum logic [PeriodW-1:0] {
    PERIOD_ONE   = 2'd0,
    PERIOD_TWO   = 2'd1,
    PERIOD_THREE = 2'd2,
    PERIOD_DAY   = 2'd3
  } period_e;

  typedef struct packed {
    logic [MarkW-1:0] mark_one;
    logic [MarkW-1:0] mark_two;
    logic [MarkW-1:0] mark_three;
    logic [MarkW-1:0] mark_four;
    logic [DutyW-1:0] duty_one;
    logic [DutyW-1:0] duty_two;
    logic [DutyW-1:0] duty_three;
    logic [LuxW-1:0]  dark_lux;
  } cfg_t;

  typedef struct packed {
    logic [HourW-1:0]  hour;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic [MarkW-1:0]  minute_of_day;
  } local_time_t;

  typedef struct packed {
    logic             lamp_on;
    logic [DutyW-1:0] duty;
    period_e          period;
  } lamp_res_t;

endpackage

[sv/streetlight_schedule_controller_top.sv]
// Top level of the streetlight schedule controller: input register, local
// time and schedule logic, result register. Depends on scc_pkg and submodules.
//
// Usage:
// Each input beat is one controller tick (UTC time and date, a seconds
// timestamp, a lux reading and a motion bit). It is accepted at a rising edge
// where in_valid_i is high and in_stall_o is low. Each accepted beat yields
// exactly one result beat: lamp on and duty, the period found and the local
// hour, day, month and year. A result is taken at an edge where out_valid_o
// is high and out_stall_i is low.
// After acceptance the beat sits in the input register while the shift,
// calendar and period logic run, and it lands in the result register at an
// edge where that register is free. Without receiver stalls, throughput is
// one beat per cycle, set by that single logic stage between the two registers.
// When the receiver stalls, the result register holds its beat and one more
// beat can still be taken into the input register; only then does
// in_stall_o rise. The dark hold timer advances as each beat moves into the
// result register, so beats are served strictly in order.
// Reset empties both registers, clears the dark hold timer and loads the
// default marks, duties and dark lux limit. Configuration writes go in
// through cfg_we_i at any edge and are meant for idle periods only.
module streetlight_schedule_controller_top #(
  parameter int unsigned DARK_HOLD_SECONDS = scc_pkg::DarkHoldDefault,
  parameter int unsigned ZONE_OFFSET_HOURS = scc_pkg::ZoneOffsetDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [scc_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [scc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Tick input channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [scc_pkg::HourW-1:0]     utc_hour_i,
  input  logic [scc_pkg::MinuteW-1:0]   utc_minute_i,
  input  logic [scc_pkg::DayW-1:0]      utc_day_i,
  input  logic [scc_pkg::MonthW-1:0]    utc_month_i,
  input  logic [scc_pkg::YearW-1:0]     utc_year_i,
  input  logic [scc_pkg::SecondsW-1:0]  now_seconds_i,
  input  logic [scc_pkg::LuxW-1:0]      lux_i,
  input  logic                          motion_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          lamp_on_o,
  output logic [scc_pkg::DutyW-1:0]     duty_percent_o,
  output logic [scc_pkg::PeriodW-1:0]   period_o,
  output logic [scc_pkg::HourW-1:0]     local_hour_o,
  output logic [scc_pkg::DayW-1:0]      local_day_o,
  output logic [scc_pkg::MonthW-1:0]    local_month_o,
  output logic [scc_pkg::YearW-1:0]     local_year_o
);
  import scc_pkg::*;

  // Input register stage.
  logic                 in_valid_q, in_valid_d;
  logic [HourW-1:0]     hour_q;
  logic [MinuteW-1:0]   minute_q;
  logic [DayW-1:0]      day_q;
  logic [MonthW-1:0]    month_q;
  logic [YearW-1:0]     year_q;
  logic [SecondsW-1:0]  now_q;
  logic [LuxW-1:0]      lux_q;
  logic                 motion_q;

  // Result register stage.
  logic                 out_valid_q, out_valid_d;
  lamp_res_t            res_q;
  local_time_t          time_q;

  cfg_t                 cfg;
  local_time_t          local_time;
  lamp_res_t            res;
  logic                 out_free;
  logic                 in_accept;
  logic                 advance;

  // The result register can take a beat when it is empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  scc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  scc_local_time #(
    .ZONE_OFFSET_HOURS (ZONE_OFFSET_HOURS)
  ) u_local_time (
    .utc_hour_i   (hour_q),
    .utc_minute_i (minute_q),
    .utc_day_i    (day_q),
    .utc_month_i  (month_q),
    .utc_year_i   (year_q),
    .local_o      (local_time)
  );

  scc_schedule #(
    .DARK_HOLD_SECONDS (DARK_HOLD_SECONDS)
  ) u_schedule (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .minute_of_day_i (local_time.minute_of_day),
    .now_seconds_i   (now_q),
    .lux_i           (lux_q),
    .motion_i        (motion_q),
    .advance_i       (advance),
    .res_o           (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset; the valid flags qualify them.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      hour_q   <= utc_hour_i;
      minute_q <= utc_minute_i;
      day_q    <= utc_day_i;
      month_q  <= utc_month_i;
      year_q   <= utc_year_i;
      now_q    <= now_seconds_i;
      lux_q    <= lux_i;
      motion_q <= motion_i;
    end
    if (advance) begin
      res_q  <= res;
      time_q <= local_time;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign lamp_on_o      = res_q.lamp_on;
  assign duty_percent_o = res_q.duty;
  assign period_o       = res_q.period;
  assign local_hour_o   = time_q.hour;
  assign local_day_o    = time_q.day;
  assign local_month_o  = time_q.month;
  assign local_year_o   = time_q.year;

endmodule

[sv/scc_cfg_regs.sv]
// Configuration register file: period marks, duties and the dark lux limit.
// Depends on scc_pkg.
module scc_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [scc_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [scc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output scc_pkg::cfg_t                cfg_o
);
  import scc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MARK_ONE:   cfg_d.mark_one   = cfg_wdata_i[MarkW-1:0];
        CFG_MARK_TWO:   cfg_d.mark_two   = cfg_wdata_i[MarkW-1:0];
        CFG_MARK_THREE: cfg_d.mark_three = cfg_wdata_i[MarkW-1:0];
        CFG_MARK_FOUR:  cfg_d.mark_four  = cfg_wdata_i[MarkW-1:0];
        CFG_DUTY_ONE:   cfg_d.duty_one   = cfg_wdata_i[DutyW-1:0];
        CFG_DUTY_TWO:   cfg_d.duty_two   = cfg_wdata_i[DutyW-1:0];
        CFG_DUTY_THREE: cfg_d.duty_three = cfg_wdata_i[DutyW-1:0];
        CFG_DARK_LUX:   cfg_d.dark_lux   = cfg_wdata_i[LuxW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mark_one   <= 11'd1080;
      cfg_q.mark_two   <= 11'd1350;
      cfg_q.mark_three <= 11'd150;
      cfg_q.mark_four  <= 11'd360;
      cfg_q.duty_one   <= 7'd100;
      cfg_q.duty_two   <= 7'd70;
      cfg_q.duty_three <= 7'd30;
      cfg_q.dark_lux   <= 16'd10;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/scc_local_time.sv]
// Time zone shift and calendar rollover with Gregorian leap years, plus the
// local minute of day. Purely combinational; depends on scc_pkg.
module scc_local_time #(
  parameter int unsigned ZONE_OFFSET_HOURS = scc_pkg::ZoneOffsetDefault
) (
  input  logic [scc_pkg::HourW-1:0]   utc_hour_i,
  input  logic [scc_pkg::MinuteW-1:0] utc_minute_i,
  input  logic [scc_pkg::DayW-1:0]    utc_day_i,
  input  logic [scc_pkg::MonthW-1:0]  utc_month_i,
  input  logic [scc_pkg::YearW-1:0]   utc_year_i,
  output scc_pkg::local_time_t        local_o
);
  import scc_pkg::*;

  localparam int unsigned YearMax    = (2 ** YearW) - 1;
  localparam int unsigned CenturyTop = YearMax / 100;

  // Multiples of 100 within the year range are few, so match them directly.
  function automatic logic is_century(input logic [YearW-1:0] year);
    logic hit;
    hit = 1'b0;
    for (int unsigned k = 0; k <= CenturyTop; k++) begin
      if (year == YearW'(k * 100)) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] month,
                                                   input logic [YearW-1:0]  year);
    logic century, leap;
    century = is_century(year);
    // A century year is a multiple of 400 exactly when it is a multiple of 16.
    leap = (year[1:0] == 2'b00) && (!century || (year[3:0] == 4'b0000));
    case (month)
      4'd3, 4'd5, 4'd8, 4'd10: month_length = 5'd30;
      4'd1:                    month_length = leap ? 5'd29 : 5'd28;
      default:                 month_length = 5'd31;
    endcase
  endfunction

  logic [HourW:0]    hour_sum;
  logic              wrap;
  logic [HourW-1:0]  hour_loc;
  logic [DayW:0]     day_inc;
  logic [MonthW:0]   month_inc;
  logic [DayW-1:0]   mlen;

  always_comb begin
    hour_sum  = {1'b0, utc_hour_i} + (HourW + 1)'(ZONE_OFFSET_HOURS);
    wrap      = hour_sum >= (HourW + 1)'(HoursPerDay);
    hour_loc  = wrap ? HourW'(hour_sum - (HourW + 1)'(HoursPerDay)) : hour_sum[HourW-1:0];
    day_inc   = {1'b0, utc_day_i} + 6'd1;
    month_inc = {1'b0, utc_month_i} + 5'd1;
    mlen      = month_length(utc_month_i, utc_year_i);

    local_o.hour  = hour_loc;
    local_o.day   = utc_day_i;
    local_o.month = utc_month_i;
    local_o.year  = utc_year_i;
    if (wrap) begin
      local_o.day = day_inc[DayW-1:0];
      if (day_inc > {1'b0, mlen}) begin
        local_o.day = 5'd1;
        if (month_inc > (MonthW + 1)'(LastMonth)) begin
          local_o.month = '0;
          local_o.year  = utc_year_i + 12'd1;
        end else begin
          local_o.month = month_inc[MonthW-1:0];
        end
      end
    end

    local_o.minute_of_day = MarkW'({6'b0, hour_loc} * MarkW'(MinutesPerHour))
                          + {5'b0, utc_minute_i};
  end

endmodule

[sv/scc_schedule.sv]
// Period selection, lamp decision and the daytime dark hold timer.
// Depends on scc_pkg.
module scc_schedule #(
  parameter int unsigned DARK_HOLD_SECONDS = scc_pkg::DarkHoldDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  scc_pkg::cfg_t                 cfg_i,
  input  logic [scc_pkg::MarkW-1:0]     minute_of_day_i,
  input  logic [scc_pkg::SecondsW-1:0]  now_seconds_i,
  input  logic [scc_pkg::LuxW-1:0]      lux_i,
  input  logic                          motion_i,
  input  logic                          advance_i,
  output scc_pkg::lamp_res_t            res_o
);
  import scc_pkg::*;

  logic [SecondsW-1:0] dark_since_q, dark_since_d;
  logic [SecondsW-1:0] since_eff;
  logic [SecondsW-1:0] elapsed;
  logic [DutyW-1:0]    night_duty;
  period_e             period;

  always_comb begin
    if (minute_of_day_i >= cfg_i.mark_one && minute_of_day_i < cfg_i.mark_two) begin
      period     = PERIOD_ONE;
      night_duty = cfg_i.duty_one;
    end else if ((minute_of_day_i >= cfg_i.mark_two &&
                  minute_of_day_i < MarkW'(MinutesPerDay)) ||
                 minute_of_day_i < cfg_i.mark_three) begin
      period     = PERIOD_TWO;
      night_duty = cfg_i.duty_two;
    end else if (minute_of_day_i >= cfg_i.mark_three &&
                 minute_of_day_i < cfg_i.mark_four) begin
      period     = PERIOD_THREE;
      night_duty = cfg_i.duty_three;
    end else begin
      period     = PERIOD_DAY;
      night_duty = '0;
    end
  end

  always_comb begin
    since_eff    = (dark_since_q == '0) ? now_seconds_i : dark_since_q;
    elapsed      = now_seconds_i - since_eff;
    dark_since_d = dark_since_q;
    res_o.period = period;
    if (period == PERIOD_DAY) begin
      res_o.lamp_on = 1'b0;
      res_o.duty    = '0;
      if (lux_i <= cfg_i.dark_lux) begin
        dark_since_d = since_eff;
        if (elapsed > SecondsW'(DARK_HOLD_SECONDS)) begin
          res_o.lamp_on = 1'b1;
          res_o.duty    = DutyFull;
        end
      end else begin
        dark_since_d = '0;
      end
    end else begin
      res_o.lamp_on = 1'b1;
      if (motion_i || night_duty > DutyFull) begin
        res_o.duty = DutyFull;
      end else begin
        res_o.duty = night_duty;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_since_q <= '0;
    end else if (advance_i) begin
      dark_since_q <= dark_since_d;
    end
  end

endmodule

[sv/scc_checker.sv]
// Port-level checks for the streetlight schedule controller, bound to the
// top level. Depends on scc_pkg and streetlight_schedule_controller_top.
module scc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          lamp_on_o,
  input logic [scc_pkg::DutyW-1:0]     duty_percent_o,
  input logic [scc_pkg::PeriodW-1:0]   period_o,
  input logic [scc_pkg::HourW-1:0]     local_hour_o,
  input logic [scc_pkg::YearW-1:0]     local_year_o
);
  import scc_pkg::*;

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(lamp_on_o) &&
      $stable(duty_percent_o) && $stable(period_o) && $stable(local_year_o))
    else $error("stalled result beat changed");

  // A dark lamp always reports zero duty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !lamp_on_o |-> duty_percent_o == '0)
    else $error("lamp off with nonzero duty");

  // Night periods always light the lamp, never above full duty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && period_o != PERIOD_DAY |-> lamp_on_o && duty_percent_o <= DutyFull)
    else $error("night period without a valid lit lamp");

  // In daytime the lamp only comes on at full duty after the dark hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && period_o == PERIOD_DAY && lamp_on_o |-> duty_percent_o == DutyFull)
    else $error("daytime lamp on below full duty");

  // The shifted hour stays inside what a single wrap can produce.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> local_hour_o != 5'd31)
    else $error("local hour out of range");

endmodule

bind streetlight_schedule_controller_top scc_checker u_scc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .lamp_on_o      (lamp_on_o),
  .duty_percent_o (duty_percent_o),
  .period_o       (period_o),
  .local_hour_o   (local_hour_o),
  .local_year_o   (local_year_o)
);

[tb/streetlight_schedule_controller_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for streetlight_schedule_controller_top: a directed tick table, then
// random ticks under six register settings, scored against typed reports or the local model.
// Depends on scc_pkg and the block's RTL only.
module streetlight_schedule_controller_top_tb;
  import scc_pkg::*;

  localparam int unsigned ClkPeriod      = 12;
  localparam int unsigned ResetCycles    = 7;
  localparam int unsigned HoldSeconds    = 60;
  localparam int unsigned ZoneHours      = 7;
  localparam int unsigned RandomTicks    = 400;
  localparam int unsigned PhaseCount     = 6;
  localparam int unsigned LongHoldCycles = 60;
  localparam int unsigned TailCycles     = 8;
  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned MaxReports     = 10;

  // Month numbers with fewer than 31 days (0 is January).
  localparam int unsigned MonFeb = 1;
  localparam int unsigned MonApr = 3;
  localparam int unsigned MonJun = 5;
  localparam int unsigned MonSep = 8;
  localparam int unsigned MonNov = 10;

  // One controller tick as it is offered on the input channel.
  typedef struct packed {
    logic [HourW-1:0]    hour;
    logic [MinuteW-1:0]  minute;
    logic [DayW-1:0]     day;
    logic [MonthW-1:0]   month;
    logic [YearW-1:0]    year;
    logic [SecondsW-1:0] now;
    logic [LuxW-1:0]     lux;
    logic                motion;
  } tick_t;

  // One lamp report as it leaves the result channel.
  typedef struct packed {
    logic              lamp_on;
    logic [DutyW-1:0]  duty;
    period_e           period;
    logic [HourW-1:0]  hour;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } lamp_report_t;

  // A directed row; the report is typed in only where it is obvious by hand.
  typedef struct {
    tick_t        tick;
    bit           has_want;
    lamp_report_t want;
  } dir_row_t;

  localparam lamp_report_t NoReport = '{1'b0, 7'd0, PERIOD_ONE, 5'd0, 5'd0, 4'd0, 12'd0};
  localparam lamp_report_t DayDark  = '{1'b0, 7'd0, PERIOD_DAY, 5'd12, 5'd10, 4'd6, 12'd2023};
  localparam lamp_report_t DayLit   = '{1'b1, 7'd100, PERIOD_DAY, 5'd12, 5'd10, 4'd6, 12'd2023};

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [HourW-1:0]     utc_hour_i;
  logic [MinuteW-1:0]   utc_minute_i;
  logic [DayW-1:0]      utc_day_i;
  logic [MonthW-1:0]    utc_month_i;
  logic [YearW-1:0]     utc_year_i;
  logic [SecondsW-1:0]  now_seconds_i;
  logic [LuxW-1:0]      lux_i;
  logic                 motion_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 lamp_on_o;
  logic [DutyW-1:0]     duty_percent_o;
  logic [PeriodW-1:0]   period_o;
  logic [HourW-1:0]     local_hour_o;
  logic [DayW-1:0]      local_day_o;
  logic [MonthW-1:0]    local_month_o;
  logic [YearW-1:0]     local_year_o;

  // Model state: register shadow, dark hold start, and reports still owed by the block.
  cfg_t                sched_cfg;
  logic [SecondsW-1:0] dark_since_q;
  lamp_report_t        lamp_reports_due[$];
  dir_row_t            dir_rows[$];

  // Random tick generator state: ticks come in runs that share a date and time of day.
  tick_t               run_base;
  int unsigned         run_left;
  bit                  run_dark;
  logic [SecondsW-1:0] stamp;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          long_hold_pending;
  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned beats_checked;
  int unsigned day_lit_count;
  int unsigned blocked_cycles;

  streetlight_schedule_controller_top #(
    .DARK_HOLD_SECONDS(HoldSeconds),
    .ZONE_OFFSET_HOURS(ZoneHours)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .utc_hour_i    (utc_hour_i),
    .utc_minute_i  (utc_minute_i),
    .utc_day_i     (utc_day_i),
    .utc_month_i   (utc_month_i),
    .utc_year_i    (utc_year_i),
    .now_seconds_i (now_seconds_i),
    .lux_i         (lux_i),
    .motion_i      (motion_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .lamp_on_o     (lamp_on_o),
    .duty_percent_o(duty_percent_o),
    .period_o      (period_o),
    .local_hour_o  (local_hour_o),
    .local_day_o   (local_day_o),
    .local_month_o (local_month_o),
    .local_year_o  (local_year_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Watchdog: a hung handshake or a lost beat ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d reports outstanding",
               cycle_count, lamp_reports_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Gregorian month length; February depends on the year before any rollover.
  function automatic int unsigned month_day_count(input int unsigned mon, input int unsigned yr);
    bit leap;
    leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    if (mon == MonApr || mon == MonJun || mon == MonSep || mon == MonNov) begin
      return 30;
    end else if (mon == MonFeb) begin
      return leap ? 29 : 28;
    end
    return 31;
  endfunction

  // Computes the lamp report for one tick and advances the dark hold. The hour wraps
  // only once, so garbage hours above 23 still land in five bits.
  function automatic lamp_report_t schedule_lamp(input tick_t t);
    lamp_report_t        r;
    int unsigned         hr;
    int unsigned         dy;
    int unsigned         mo;
    int unsigned         yr;
    int unsigned         day_min;
    logic [SecondsW-1:0] elapsed;
    logic [DutyW-1:0]    duty_raw;
    hr = t.hour + ZoneHours;
    dy = t.day;
    mo = t.month;
    yr = t.year;
    duty_raw = '0;
    if (hr >= HoursPerDay) begin
      hr -= HoursPerDay;
      dy++;
      if (dy > month_day_count(mo, yr)) begin
        dy = 1;
        mo++;
        if (mo > LastMonth) begin
          mo = 0;
          yr++;
        end
      end
    end

    // The marks are tested in this fixed order, so overlapping marks resolve early.
    day_min = hr * MinutesPerHour + t.minute;
    if (day_min >= sched_cfg.mark_one && day_min < sched_cfg.mark_two) begin
      r.period = PERIOD_ONE;
      duty_raw = sched_cfg.duty_one;
    end else if ((day_min >= sched_cfg.mark_two && day_min < MinutesPerDay) ||
                 day_min < sched_cfg.mark_three) begin
      r.period = PERIOD_TWO;
      duty_raw = sched_cfg.duty_two;
    end else if (day_min >= sched_cfg.mark_three && day_min < sched_cfg.mark_four) begin
      r.period = PERIOD_THREE;
      duty_raw = sched_cfg.duty_three;
    end else begin
      r.period = PERIOD_DAY;
    end

    if (r.period == PERIOD_DAY) begin
      r.lamp_on = 1'b0;
      r.duty = '0;
      if (t.lux <= sched_cfg.dark_lux) begin
        // A hold started at timestamp zero looks idle and restarts on the next dark tick.
        if (dark_since_q == '0) begin
          dark_since_q = t.now;
        end
        elapsed = t.now - dark_since_q;
        if (elapsed > HoldSeconds) begin
          r.lamp_on = 1'b1;
          r.duty = DutyFull;
        end
      end else begin
        dark_since_q = '0;
      end
    end else begin
      r.lamp_on = 1'b1;
      r.duty = t.motion ? DutyFull : ((duty_raw > DutyFull) ? DutyFull : duty_raw);
    end

    r.hour = HourW'(hr);
    r.day = DayW'(dy);
    r.month = MonthW'(mo);
    r.year = YearW'(yr);
    return r;
  endfunction

  // Mostly runs of well-formed ticks at one date and time with the timestamp creeping up,
  // so the dark hold can expire; the rest is unconstrained noise on every field.
  function automatic tick_t random_tick();
    tick_t       t;
    int unsigned mdays;
    if ($urandom_range(99) < 15) begin
      t.hour = HourW'($urandom);
      t.minute = MinuteW'($urandom);
      t.day = DayW'($urandom);
      t.month = MonthW'($urandom);
      t.year = YearW'($urandom);
      t.now = ($urandom_range(9) == 0) ? '0 : $urandom;
      t.lux = LuxW'($urandom);
      t.motion = 1'($urandom);
      return t;
    end
    if (run_left == 0) begin
      run_left = $urandom_range(10, 4);
      run_dark = ($urandom_range(99) < 65);
      run_base.hour = HourW'($urandom_range(23));
      run_base.minute = MinuteW'($urandom_range(59));
      run_base.month = MonthW'($urandom_range(LastMonth));
      case ($urandom_range(3))
        0: run_base.year = YearW'(4 * $urandom_range(1023));
        1: run_base.year = YearW'(100 * $urandom_range(40));
        default: run_base.year = YearW'($urandom);
      endcase
      mdays = month_day_count(run_base.month, run_base.year);
      run_base.day = DayW'(($urandom_range(2) == 0) ? mdays : $urandom_range(mdays, 1));
      if ($urandom_range(19) == 0) begin
        stamp = $urandom;
      end
    end
    run_left--;
    stamp = ($urandom_range(29) == 0) ? '0 : stamp + $urandom_range(25);
    t = run_base;
    t.now = stamp;
    t.lux = run_dark ? LuxW'($urandom_range(sched_cfg.dark_lux)) : LuxW'($urandom);
    t.motion = 1'($urandom);
    return t;
  endfunction

  // Offers one tick, holds it steady until the block takes it, then books the report.
  task automatic offer_tick(input tick_t t, input bit has_want, input lamp_report_t want);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    utc_hour_i    <= t.hour;
    utc_minute_i  <= t.minute;
    utc_day_i     <= t.day;
    utc_month_i   <= t.month;
    utc_year_i    <= t.year;
    now_seconds_i <= t.now;
    lux_i         <= t.lux;
    motion_i      <= t.motion;
    taken = 1'b0;
    // The stall is read mid-cycle, where it is settled for the coming edge.
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    // The model always runs so the dark hold tracks directed rows too.
    if (has_want) begin
      void'(schedule_lamp(t));
      lamp_reports_due.push_back(want);
    end else begin
      lamp_reports_due.push_back(schedule_lamp(t));
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_MARK_ONE:   sched_cfg.mark_one = data[MarkW-1:0];
      CFG_MARK_TWO:   sched_cfg.mark_two = data[MarkW-1:0];
      CFG_MARK_THREE: sched_cfg.mark_three = data[MarkW-1:0];
      CFG_MARK_FOUR:  sched_cfg.mark_four = data[MarkW-1:0];
      CFG_DUTY_ONE:   sched_cfg.duty_one = data[DutyW-1:0];
      CFG_DUTY_TWO:   sched_cfg.duty_two = data[DutyW-1:0];
      CFG_DUTY_THREE: sched_cfg.duty_three = data[DutyW-1:0];
      CFG_DARK_LUX:   sched_cfg.dark_lux = data[LuxW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfg_t c);
    write_reg(CFG_MARK_ONE, CfgDataW'(c.mark_one));
    write_reg(CFG_MARK_TWO, CfgDataW'(c.mark_two));
    write_reg(CFG_MARK_THREE, CfgDataW'(c.mark_three));
    write_reg(CFG_MARK_FOUR, CfgDataW'(c.mark_four));
    write_reg(CFG_DUTY_ONE, CfgDataW'(c.duty_one));
    write_reg(CFG_DUTY_TWO, CfgDataW'(c.duty_two));
    write_reg(CFG_DUTY_THREE, CfgDataW'(c.duty_three));
    write_reg(CFG_DARK_LUX, CfgDataW'(c.dark_lux));
    cfg_we_i <= 1'b0;
  endtask

  // Registers change only once every report is in and the pipeline has gone quiet.
  task automatic wait_drained();
    while (lamp_reports_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // Result side: checks each beat taken and picks the stall for the next cycle. A long
  // hold requested by the stimulus is counted down here while ticks keep coming.
  initial begin : result_sink
    lamp_report_t got;
    lamp_report_t want;
    int unsigned  hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (in_valid_i && in_stall_o) begin
        blocked_cycles++;
      end
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = '{lamp_on_o, duty_percent_o, period_e'(period_o), local_hour_o,
                local_day_o, local_month_o, local_year_o};
        if (lamp_reports_due.size() == 0) begin
          if (mismatch_count < MaxReports) begin
            $display("Result beat %0d arrived with no report awaited", beats_checked);
          end
          mismatch_count++;
        end else begin
          want = lamp_reports_due.pop_front();
          if (got.lamp_on !== want.lamp_on || got.duty !== want.duty ||
              got.period !== want.period || got.hour !== want.hour ||
              got.day !== want.day || got.month !== want.month || got.year !== want.year) begin
            if (mismatch_count < MaxReports) begin
              $display("Result beat %0d: expected lamp %0d duty %0d period %0d %0d:%0d/%0d/%0d",
                       beats_checked, want.lamp_on, want.duty, want.period, want.hour,
                       want.day, want.month, want.year);
              $display("  actual lamp %0d duty %0d period %0d %0d:%0d/%0d/%0d",
                       got.lamp_on, got.duty, got.period, got.hour, got.day, got.month,
                       got.year);
            end
            mismatch_count++;
          end
          if (want.period == PERIOD_DAY && want.lamp_on) begin
            day_lit_count++;
          end
        end
        beats_checked++;
      end
      @(posedge clk_i);
      if (long_hold_pending) begin
        hold_left = LongHoldCycles;
        long_hold_pending = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    cfg_t        setting;
    int unsigned mode;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_MARK_ONE;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    utc_hour_i    <= '0;
    utc_minute_i  <= '0;
    utc_day_i     <= '0;
    utc_month_i   <= '0;
    utc_year_i    <= '0;
    now_seconds_i <= '0;
    lux_i         <= '0;
    motion_i      <= 1'b0;
    sched_cfg = '{11'd1080, 11'd1350, 11'd150, 11'd360, 7'd100, 7'd70, 7'd30, 16'd10};
    dark_since_q = '0;
    run_left = 0;
    stamp = '0;
    long_hold_pending = 1'b0;
    send_idle_pct = 11;
    recv_idle_pct = 82;

    // Directed rows under the reset settings. Night rows cover each period, motion,
    // leap and non-leap February, and the year wrapping to zero on New Year.
    dir_rows.push_back('{'{5'd11, 6'd0, 5'd1, 4'd0, 12'd2023, 32'd1000, 16'd500, 1'b0}, 1'b1,
                         '{1'b1, 7'd100, PERIOD_ONE, 5'd18, 5'd1, 4'd0, 12'd2023}});
    dir_rows.push_back('{'{5'd16, 6'd30, 5'd5, 4'd3, 12'd2024, 32'd1010, 16'd3, 1'b0}, 1'b1,
                         '{1'b1, 7'd70, PERIOD_TWO, 5'd23, 5'd5, 4'd3, 12'd2024}});
    dir_rows.push_back('{'{5'd17, 6'd0, 5'd31, 4'd11, 12'd4095, 32'd1020, 16'd0, 1'b1}, 1'b1,
                         '{1'b1, 7'd100, PERIOD_TWO, 5'd0, 5'd1, 4'd0, 12'd0}});
    dir_rows.push_back('{'{5'd20, 6'd0, 5'd28, 4'd1, 12'd2024, 32'd1030, 16'd0, 1'b0}, 1'b1,
                         '{1'b1, 7'd30, PERIOD_THREE, 5'd3, 5'd29, 4'd1, 12'd2024}});
    dir_rows.push_back('{'{5'd20, 6'd0, 5'd28, 4'd1, 12'd1900, 32'd1040, 16'd0, 1'b0}, 1'b1,
                         '{1'b1, 7'd30, PERIOD_THREE, 5'd3, 5'd1, 4'd2, 12'd1900}});
    dir_rows.push_back('{'{5'd18, 6'd0, 5'd29, 4'd1, 12'd2000, 32'd1050, 16'd0, 1'b0}, 1'b1,
                         '{1'b1, 7'd70, PERIOD_TWO, 5'd1, 5'd1, 4'd2, 12'd2000}});
    // Daytime at local noon: bright, dark hold at the limit, expiry one second past it,
    // motion ignored, a hold started at timestamp zero, and a hold across the wrap.
    dir_rows.push_back('{'{5'd5, 6'd0, 5'd10, 4'd6, 12'd2023, 32'd2000, 16'd500, 1'b0}, 1'b1,
                         DayDark});
    dir_rows.push_back('{'{5'd5, 6'd0, 5'd10, 4'd6, 12'd2023, 32'd2000, 16'd5, 1'b0}, 1'b1,
                         DayDark});
    dir_rows.push_back('{'{5'd5, 6'd0, 5'd10, 4'd6, 12'd2023, 32'd2060, 16'd10, 1'b0}, 1'b1,
                         DayDark});
    dir_rows.push_back('{'{5'd5, 6'd0, 5'd10, 4'd6, 12'd2023, 32'd2061, 16'd0, 1'b0}, 1'b1,
                         DayLit});
    dir_rows.push_back('{'{5'd5, 6'd0, 5'd10, 4'd6, 12'd2023, 32'd2070, 16'hFFFF, 1'b1}, 1'b1,
                         DayDark});
    dir_rows.push_back('{'{5'd5, 6'd0, 5'd10, 4'd6, 12'd2023, 32'd0, 16'd0, 1'b0}, 1'b1,
                         DayDark});
    dir_rows.push_back('{'{5'd5, 6'd0, 5'd10, 4'd6, 12'd2023, 32'd5, 16'd0, 1'b0}, 1'b1,
                         DayDark});
    dir_rows.push_back('{'{5'd5, 6'd0, 5'd10, 4'd6, 12'd2023, 32'd66, 16'd0, 1'b0}, 1'b1,
                         DayLit});
    dir_rows.push_back('{'{5'd5, 6'd0, 5'd10, 4'd6, 12'd2023, 32'd100, 16'd11, 1'b0}, 1'b1,
                         DayDark});
    dir_rows.push_back('{'{5'd5, 6'd0, 5'd10, 4'd6, 12'd2023, 32'd200, 16'd0, 1'b0}, 1'b0,
                         NoReport});
    dir_rows.push_back('{'{5'd5, 6'd0, 5'd10, 4'd6, 12'd2023, 32'd150, 16'd0, 1'b0}, 1'b0,
                         NoReport});
    // Field extremes and out-of-range calendar values, plus the period boundaries.
    dir_rows.push_back('{'{5'd31, 6'd63, 5'd31, 4'd15, 12'd4095, 32'hFFFF_FFFF, 16'hFFFF, 1'b1},
                         1'b0, NoReport});
    dir_rows.push_back('{'{5'd0, 6'd0, 5'd0, 4'd0, 12'd0, 32'd0, 16'd0, 1'b0}, 1'b0, NoReport});
    dir_rows.push_back('{'{5'd0, 6'd0, 5'd15, 4'd13, 12'd100, 32'd300, 16'd20, 1'b0}, 1'b0,
                         NoReport});
    dir_rows.push_back('{'{5'd19, 6'd30, 5'd0, 4'd4, 12'd2023, 32'd310, 16'd20, 1'b0}, 1'b0,
                         NoReport});
    dir_rows.push_back('{'{5'd19, 6'd29, 5'd30, 4'd3, 12'd2023, 32'd320, 16'd20, 1'b0}, 1'b0,
                         NoReport});
    dir_rows.push_back('{'{5'd16, 6'd59, 5'd31, 4'd3, 12'd2023, 32'd330, 16'd20, 1'b1}, 1'b0,
                         NoReport});
    dir_rows.push_back('{'{5'd23, 6'd0, 5'd31, 4'd15, 12'd2023, 32'd340, 16'd20, 1'b0}, 1'b0,
                         NoReport});
    dir_rows.push_back('{'{5'd10, 6'd59, 5'd1, 4'd0, 12'd2023, 32'd350, 16'd20, 1'b0}, 1'b0,
                         NoReport});

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      offer_tick(dir_rows[i].tick, dir_rows[i].has_want, dir_rows[i].want);
    end
    in_valid_i <= 1'b0;

    // Random phases, each under its own settings: all zero, all ones, the reset values,
    // a crossed schedule with an over-range duty, then two random settings.
    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      wait_drained();
      case (phase)
        0: setting = '0;
        1: setting = '1;
        2: setting = '{11'd1080, 11'd1350, 11'd150, 11'd360, 7'd100, 7'd70, 7'd30, 16'd10};
        3: setting = '{11'd0, 11'd1439, 11'd720, 11'd1439, 7'd101, 7'd100, 7'd1, 16'd200};
        4: setting = '{MarkW'($urandom_range(1439)), MarkW'($urandom_range(1439)),
                       MarkW'($urandom_range(1439)), MarkW'($urandom_range(1439)),
                       DutyW'($urandom_range(100)), DutyW'($urandom_range(100)),
                       DutyW'($urandom_range(100)), LuxW'($urandom_range(2000))};
        default: setting = '{MarkW'($urandom), MarkW'($urandom), MarkW'($urandom),
                             MarkW'($urandom), DutyW'($urandom), DutyW'($urandom),
                             DutyW'($urandom), LuxW'($urandom)};
      endcase
      apply_settings(setting);

      // Two phases per idling pattern: slow receiver, then slow sender, then full speed.
      mode = phase / 2;
      case (mode)
        0: begin
          send_idle_pct = 11;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 11;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // At full speed the receiver freezes for a while so the block backs up to its input.
      if (phase == 4) begin
        long_hold_pending = 1'b1;
      end

      repeat (RandomTicks / PhaseCount) begin
        offer_tick(random_tick(), 1'b0, NoReport);
      end
      in_valid_i <= 1'b0;
    end

    wait_drained();
    $display("Checked %0d lamp reports from directed rows and %0d register settings;",
             beats_checked, PhaseCount + 1);
    $display("%0d daytime dark-hold lamp-ons, %0d cycles with the input held off.",
             day_lit_count, blocked_cycles);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
